/* hw/rtl/hybrid_rle_bitpack_encoder_top_defines.svh */
// Assertion macros for the hybrid RLE / bit-packing encoder.
// Depends on nothing; included by the checker file.
`ifndef HYBRID_RLE_BITPACK_ENCODER_TOP_DEFINES_SVH
`define HYBRID_RLE_BITPACK_ENCODER_TOP_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define HRBE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define HRBE_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/hrbe_pkg.sv */
// Shared types and constants of the hybrid RLE / bit-packing encoder.
// Used by the top level, the byte packer and the checker.
package hrbe_pkg;

   localparam int BUF_DEPTH = 64;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;
   localparam int VAL_W     = 32;
   localparam int WID_W     = 6;
   localparam int LEN_W     = 6;
   localparam int RUN_MIN   = 8;
   localparam int ACC_W     = 96;
   localparam int NB_W      = 7;
   localparam int WORD_W    = 64;

   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_BP,
      JOB_RLE
   } job_kind_type;

   // One segment to be written out.
   typedef struct packed {
      job_kind_type     kind;
      logic [CNT_W-1:0] count;
      logic [VAL_W-1:0] value;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_RLE_VAL,
      ST_BP_RD,
      ST_BP_APPEND,
      ST_NEXT,
      ST_TAIL
   } state_type;

   // Request from the sequencer to the byte packer.
   typedef struct packed {
      logic             append;
      logic [VAL_W-1:0] data;
      logic [LEN_W-1:0] len;
      logic             finish;
      logic             eos;
   } pk_req_type;

   // Status from the byte packer.
   typedef struct packed {
      logic room;
      logic fin_done;
   } pk_stat_type;

endpackage

/* hw/rtl/hybrid_rle_bitpack_encoder_top.sv */
// Top level of the hybrid RLE / bit-packing encoder: value buffer memory,
// run tracking and the segment sequencer. Depends on hrbe_pkg and hrbe_packer.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | value, final_value
//   rsp     | out       | rsp_valid/ready    | out_bytes, byte_count, flags
//   csr     | in        | csr_wr_en          | value_bit_width
//
// An item that emits nothing passes through accept and tail. Each segment
// adds a header and a hand-over state, an RLE segment a state for its value,
// and a bit-packed segment a read and an append state per value slot (groups*8).
// An append waits while more than one word sits in the accumulator.
// Reset clears the control state; the buffer memory needs no clearing pass.
// A stalled result channel holds the sequencer once the accumulator is full.
module hybrid_rle_bitpack_encoder_top import hrbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [VAL_W-1:0]  req_value,
   input  logic              req_final_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_out_bytes,
   output logic [3:0]        rsp_byte_count,
   output logic              rsp_last_of_item,
   output logic              rsp_end_of_stream,
   input  logic              csr_wr_en,
   input  logic [WID_W-1:0]  csr_wr_data
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, run_length_ff, idx_ff, idx_in;
   logic [VAL_W-1:0] run_value_ff, rd_data_ff;
   logic [WID_W-1:0] width_cfg_ff;
   job_type          job0_ff, job0_in, job1_ff, job1_in;
   logic             fin_ff, fin_in;
   logic [VAL_W-1:0] buf_mem [BUF_DEPTH];

   logic             accept;
   logic [WID_W-1:0] w;
   logic [VAL_W-1:0] v_m;
   logic [CNT_W-1:0] dec_fill, dec_rl;
   logic [VAL_W-1:0] dec_rv;
   job_type          dec_j0, dec_j1;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [3:0]       groups;
   logic [CNT_W-1:0] bp_total;
   logic [7:0]       hdr;
   logic [VAL_W-1:0] hdr_data;
   logic [LEN_W-1:0] hdr_len;
   logic [LEN_W-1:0] rle_len;
   pk_req_type       pk_req;
   pk_stat_type      pk_stat;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Effective width and masked input value.
   always_comb begin
      w   = (width_cfg_ff > WID_W'(VAL_W)) ? WID_W'(VAL_W) : width_cfg_ff;
      v_m = req_value & VAL_W'((33'd1 << w) - 33'd1);
   end

   // Run tracking: new state and up to two segments for the item.
   always_comb begin
      job_type          jb;
      logic [CNT_W-1:0] f;
      logic [CNT_W-1:0] rl;
      logic [VAL_W-1:0] rv;
      f       = fill_ff;
      rl      = run_length_ff;
      rv      = run_value_ff;
      dec_j0  = '{kind: JOB_NONE, count: '0, value: '0};
      dec_j1  = '{kind: JOB_NONE, count: '0, value: '0};
      jb      = '{kind: JOB_NONE, count: '0, value: '0};
      wr_addr = fill_ff[IDX_W-1:0];
      if (fill_ff == '0) begin
         rv      = v_m;
         rl      = CNT_W'(1);
         wr_addr = '0;
         f       = CNT_W'(1);
      end else if (v_m == run_value_ff) begin
         rl      = rl + CNT_W'(1);
         wr_addr = f[IDX_W-1:0];
         f       = f + CNT_W'(1);
         if (rl >= CNT_W'(RUN_MIN) && f > rl) begin
            dec_j0 = '{kind: JOB_BP, count: f - rl, value: '0};
            f      = rl;
         end
         // A full buffer leaves as a run only when the run is long enough.
         if (f >= CNT_W'(BUF_DEPTH)) begin
            if (rl >= CNT_W'(RUN_MIN)) begin
               jb = '{kind: JOB_RLE, count: rl, value: rv};
            end else begin
               jb = '{kind: JOB_BP, count: f, value: '0};
            end
            f  = '0;
            rl = '0;
         end
      end else begin
         if (rl >= CNT_W'(RUN_MIN)) begin
            dec_j0 = '{kind: JOB_RLE, count: rl, value: rv};
            f      = '0;
         end
         rv      = v_m;
         rl      = CNT_W'(1);
         wr_addr = f[IDX_W-1:0];
         f       = f + CNT_W'(1);
         if (f >= CNT_W'(BUF_DEPTH)) begin
            jb = '{kind: JOB_BP, count: f, value: '0};
            f  = '0;
            rl = '0;
         end
      end
      if (req_final_value && f != '0) begin
         if (rl >= CNT_W'(RUN_MIN)) begin
            jb = '{kind: JOB_RLE, count: rl, value: rv};
         end else begin
            jb = '{kind: JOB_BP, count: f, value: '0};
         end
         f  = '0;
         rl = '0;
      end
      // The second segment goes into the first free slot.
      if (dec_j0.kind == JOB_NONE) begin
         dec_j0 = jb;
      end else begin
         dec_j1 = jb;
      end
      dec_fill = f;
      dec_rl   = rl;
      dec_rv   = rv;
   end

   // Segment header and length helpers.
   always_comb begin
      groups   = 4'((job0_ff.count + CNT_W'(7)) >> 3);
      bp_total = {groups, 3'b000};
      if (job0_ff.kind == JOB_RLE) begin
         hdr = {job0_ff.count, 1'b0};
      end else begin
         hdr = {3'b000, groups, 1'b1};
      end
      if (hdr[7]) begin
         hdr_data = {23'd0, hdr[7], 1'b1, hdr[6:0]};
         hdr_len  = LEN_W'(16);
      end else begin
         hdr_data = {24'd0, hdr};
         hdr_len  = LEN_W'(8);
      end
      rle_len = {3'b000, 3'((w + WID_W'(7)) >> 3)} << 3;
   end

   // Sequencer next state and packer requests.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      job0_in  = job0_ff;
      job1_in  = job1_ff;
      fin_in   = fin_ff;
      rd_en    = 1'b0;
      pk_req   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               job0_in  = dec_j0;
               job1_in  = dec_j1;
               fin_in   = req_final_value;
               state_in = (dec_j0.kind != JOB_NONE) ? ST_HDR : ST_TAIL;
            end
         end
         ST_HDR: begin
            pk_req.append = 1'b1;
            pk_req.data   = hdr_data;
            pk_req.len    = hdr_len;
            if (pk_stat.room) begin
               idx_in   = '0;
               state_in = (job0_ff.kind == JOB_RLE) ? ST_RLE_VAL : ST_BP_RD;
            end
         end
         ST_RLE_VAL: begin
            pk_req.append = 1'b1;
            pk_req.data   = job0_ff.value;
            pk_req.len    = rle_len;
            if (pk_stat.room) begin
               state_in = ST_NEXT;
            end
         end
         ST_BP_RD: begin
            rd_en    = (idx_ff < job0_ff.count);
            state_in = ST_BP_APPEND;
         end
         ST_BP_APPEND: begin
            pk_req.append = 1'b1;
            pk_req.data   = (idx_ff < job0_ff.count) ? rd_data_ff : '0;
            pk_req.len    = LEN_W'(w);
            if (pk_stat.room) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = (idx_ff == bp_total - CNT_W'(1)) ? ST_NEXT : ST_BP_RD;
            end
         end
         ST_NEXT: begin
            job0_in  = job1_ff;
            job1_in  = '{kind: JOB_NONE, count: '0, value: '0};
            state_in = (job1_ff.kind != JOB_NONE) ? ST_HDR : ST_TAIL;
         end
         ST_TAIL: begin
            pk_req.finish = 1'b1;
            pk_req.eos    = fin_ff;
            if (pk_stat.fin_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and run state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         run_length_ff <= '0;
         run_value_ff  <= '0;
         width_cfg_ff  <= WID_W'(1);
         fin_ff        <= 1'b0;
         idx_ff        <= '0;
         job0_ff       <= '{kind: JOB_NONE, count: '0, value: '0};
         job1_ff       <= '{kind: JOB_NONE, count: '0, value: '0};
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         idx_ff   <= idx_in;
         job0_ff  <= job0_in;
         job1_ff  <= job1_in;
         if (accept) begin
            fill_ff       <= dec_fill;
            run_length_ff <= dec_rl;
            run_value_ff  <= dec_rv;
         end
         if (csr_wr_en) begin
            width_cfg_ff <= csr_wr_data;
         end
      end
   end

   // Value buffer: one write port at the fill position, one registered read.
   always_ff @(posedge clock) begin
      if (accept) begin
         buf_mem[wr_addr] <= v_m;
      end
      if (rd_en) begin
         rd_data_ff <= buf_mem[idx_ff[IDX_W-1:0]];
      end
   end

   hrbe_packer u_packer (
      .clock             (clock),
      .reset             (reset),
      .pk_req            (pk_req),
      .pk_stat           (pk_stat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_bytes     (rsp_out_bytes),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

endmodule

/* hw/rtl/hrbe_packer.sv */
// Bit accumulator and output word register of the encoder.
// Depends on hrbe_pkg.
module hrbe_packer import hrbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  pk_req_type        pk_req,
   output pk_stat_type       pk_stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_out_bytes,
   output logic [3:0]        rsp_byte_count,
   output logic              rsp_last_of_item,
   output logic              rsp_end_of_stream
);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [NB_W-1:0]   nbits_ff, nbits_in;
   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] bytes_ff, bytes_in;
   logic [3:0]        count_ff, count_in;
   logic              last_ff, last_in;
   logic              eos_ff, eos_in;
   logic              out_free;
   logic              room;
   logic              fin_done;

   // Bits are appended at the top of the accumulator; full words leave once
   // more than one word is held, so the last word of an item is known.
   always_comb begin
      out_free = !valid_ff || rsp_ready;
      room     = (nbits_ff <= NB_W'(WORD_W));
      acc_in   = acc_ff;
      nbits_in = nbits_ff;
      valid_in = valid_ff && !rsp_ready;
      bytes_in = bytes_ff;
      count_in = count_ff;
      last_in  = last_ff;
      eos_in   = eos_ff;
      fin_done = 1'b0;
      if (!room) begin
         if (out_free) begin
            valid_in = 1'b1;
            bytes_in = acc_ff[WORD_W-1:0];
            count_in = 4'd8;
            last_in  = 1'b0;
            eos_in   = 1'b0;
            acc_in   = acc_ff >> WORD_W;
            nbits_in = nbits_ff - NB_W'(WORD_W);
         end
      end else if (pk_req.append) begin
         acc_in   = acc_ff | ({(ACC_W-VAL_W)'(0), pk_req.data} << nbits_ff);
         nbits_in = nbits_ff + NB_W'(pk_req.len);
      end else if (pk_req.finish && out_free) begin
         fin_done = 1'b1;
         if (nbits_ff != '0) begin
            valid_in = 1'b1;
            bytes_in = acc_ff[WORD_W-1:0];
            count_in = nbits_ff[6:3];
            last_in  = 1'b1;
            eos_in   = pk_req.eos;
         end
         acc_in   = '0;
         nbits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         nbits_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         nbits_ff <= nbits_in;
         valid_ff <= valid_in;
      end
      bytes_ff <= bytes_in;
      count_ff <= count_in;
      last_ff  <= last_in;
      eos_ff   <= eos_in;
   end

   assign pk_stat.room      = room;
   assign pk_stat.fin_done  = fin_done;
   assign rsp_valid         = valid_ff;
   assign rsp_out_bytes     = bytes_ff;
   assign rsp_byte_count    = count_ff;
   assign rsp_last_of_item  = last_ff;
   assign rsp_end_of_stream = eos_ff;

endmodule

/* hw/rtl/hrbe_checker.sv */
// Port-level checks of the hybrid RLE / bit-packing encoder, bound to the top.
// Depends on hrbe_pkg and the assertion macro header.
`include "hybrid_rle_bitpack_encoder_top_defines.svh"

module hrbe_checker import hrbe_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_out_bytes,
   input logic [3:0]        rsp_byte_count,
   input logic              rsp_last_of_item,
   input logic              rsp_end_of_stream
);

   // A word that is not the last of its item is always full.
   `HRBE_ASSERT(a_full_word, clock, reset, rsp_valid && !rsp_last_of_item |-> rsp_byte_count == 4'd8, "non-final word not full")

   // The byte count is never zero and never above eight.
   `HRBE_ASSERT(a_count_range, clock, reset, rsp_valid |-> rsp_byte_count != 4'd0 && rsp_byte_count <= 4'd8, "byte count out of range")

   // The end of the stream is always the last word of an item.
   `HRBE_ASSERT(a_eos_last, clock, reset, rsp_valid && rsp_end_of_stream |-> rsp_last_of_item, "end of stream without last word")

   // A stalled word holds its bytes.
   `HRBE_ASSERT(a_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_bytes), "stalled word changed")

   // No word is shown right after reset.
   `HRBE_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid, "word valid after reset")

endmodule

bind hybrid_rle_bitpack_encoder_top hrbe_checker u_hrbe_checker (.*);
